[hw/rtl/adcah_pkg.sv]
// Package with shared constants, types and range tables of the ADC autorange block.
package adcah_pkg;

  localparam int CHANNELS    = 4;
  localparam int RANGE_COUNT = 3;

  localparam int CH_W       = 2;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RANGE_W    = 2;
  localparam int CODE_W     = 16;
  localparam int VALUE_W    = 15;
  localparam int LEVEL_W    = 16;
  localparam int RATE_W     = 3;
  localparam int WORD_W     = 16;
  localparam int SETTLE_W   = 2;
  localparam int GEN_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 31;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_CODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_LEVEL_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_LEVEL_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_LEVEL_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_LEVEL_2 = 3'd4;

  localparam logic [RATE_W-1:0]  RATE_CODE_RST    = 3'd4;
  localparam logic [LEVEL_W-1:0] UP_LEVEL_0_RST   = 16'd572;
  localparam logic [LEVEL_W-1:0] UP_LEVEL_1_RST   = 16'd4160;
  localparam logic [LEVEL_W-1:0] DOWN_LEVEL_1_RST = 16'd500;
  localparam logic [LEVEL_W-1:0] DOWN_LEVEL_2_RST = 16'd3840;

  localparam logic [RANGE_W-1:0] RANGE_WIDEST = RANGE_W'(RANGE_COUNT - 1);
  localparam logic [PROD_W-1:0]  ROUND_HALF   = 31'd16384;
  localparam int                 SCALE_SHIFT  = 15;

  localparam logic [2:0]          MUX_SINGLE_BASE = 3'd4;
  localparam logic [1:0]          COMP_OFF        = 2'b11;
  localparam logic [SETTLE_W-1:0] SETTLE_LONG     = 2'd3;
  localparam logic [SETTLE_W-1:0] SETTLE_SHORT    = 2'd1;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_code;
    logic [LEVEL_W-1:0] up_level_0;
    logic [LEVEL_W-1:0] up_level_1;
    logic [LEVEL_W-1:0] down_level_1;
    logic [LEVEL_W-1:0] down_level_2;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  tenth_mv;
    logic [RANGE_W-1:0]  range_used;
    logic [RANGE_W-1:0]  next_range;
    logic [WORD_W-1:0]   next_config_word;
    logic [SETTLE_W-1:0] settle_count;
  } result_t;

  // Full scale times ten, so the product lands in tenths of a millivolt.
  function automatic logic [15:0] full_scale_x10(input logic [RANGE_W-1:0] idx);
    logic [15:0] fs;
    case (idx)
      2'd0:    fs = 16'd2560;
      2'd1:    fs = 16'd5120;
      default: fs = 16'd20480;
    endcase
    return fs;
  endfunction

  function automatic logic [2:0] pga_code(input logic [RANGE_W-1:0] idx);
    logic [2:0] code;
    case (idx)
      2'd0:    code = 3'd5;
      2'd1:    code = 3'd4;
      default: code = 3'd2;
    endcase
    return code;
  endfunction

  function automatic logic is_narrowest(input logic [RANGE_W-1:0] idx);
    return idx == 2'd0;
  endfunction

endpackage

[hw/rtl/adcah_smp_if.sv]
// Input channel interface carrying one converted code and its channel number.
interface adcah_smp_if;
  logic                                 valid;
  logic                                 ready;
  logic [adcah_pkg::CH_W-1:0]           channel;
  logic signed [adcah_pkg::CODE_W-1:0]  sample_code;

  modport source(output valid, channel, sample_code, input ready);
  modport sink(input valid, channel, sample_code, output ready);
endinterface

[hw/rtl/adcah_res_if.sv]
// Output channel interface carrying one scaled result with its range and config word.
interface adcah_res_if;
  logic                                valid;
  logic                                ready;
  logic [adcah_pkg::VALUE_W-1:0]       tenth_mv;
  logic [adcah_pkg::RANGE_W-1:0]       range_used;
  logic [adcah_pkg::RANGE_W-1:0]       next_range;
  logic [adcah_pkg::WORD_W-1:0]        next_config_word;
  logic [adcah_pkg::SETTLE_W-1:0]      settle_count;
  logic [adcah_pkg::GEN_W-1:0]         generation;

  modport source(output valid, tenth_mv, range_used, next_range, next_config_word,
                 settle_count, generation, input ready);
  modport sink(input valid, tenth_mv, range_used, next_range, next_config_word,
               settle_count, generation, output ready);
endinterface

[hw/rtl/adc_autorange_hysteresis_core.sv]
// Top level of the per-channel ADC autorange block with hysteresis.
//
//   Port        Dir    Handshake      Content
//   smp         in     valid/ready    channel, sample_code
//   res         out    valid/ready    value, ranges, config word, settle count, generation
//   cfg_*       in     write enable   register index and data
//
// One request enters per cycle unless the result stalls, and is taken into the input register.
// The input register feeds the scaling multiply and threshold compare, which load the
// result register and update the channel's range in the same cycle.
// Reset sets all channel ranges to the widest range and clears the generation count.
// A stalled result holds the result register, and the input register still takes one
// more request while the result waits.
module adc_autorange_hysteresis_core (
  input  logic                              clk,
  input  logic                              rst,
  adcah_smp_if.sink                         smp,
  adcah_res_if.source                       res,
  input  logic                              cfg_we,
  input  logic [adcah_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adcah_pkg::CFG_DATA_W-1:0]  cfg_data
);

  adcah_pkg::cfg_t                     cfg;
  adcah_pkg::result_t                  result;

  logic                                s1_valid;
  logic [adcah_pkg::CH_W-1:0]          s1_channel;
  logic signed [adcah_pkg::CODE_W-1:0] s1_raw;

  logic [adcah_pkg::RANGE_W-1:0]       chan_range [adcah_pkg::CHANNELS];
  logic [adcah_pkg::GEN_W-1:0]         sample_count;
  logic [adcah_pkg::GEN_W-1:0]         sample_count_next;

  logic                                ch_ok;
  logic [adcah_pkg::RANGE_W-1:0]       stored;
  logic [adcah_pkg::RANGE_W-1:0]       cur_range;
  logic                                advance;
  logic                                fire;

  adcah_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign ch_ok  = 32'(s1_channel) < 32'(adcah_pkg::CHANNELS);
  assign stored = ch_ok ? chan_range[s1_channel[adcah_pkg::CH_IDX_W-1:0]]
                        : adcah_pkg::RANGE_WIDEST;
  assign cur_range = (32'(stored) >= 32'(adcah_pkg::RANGE_COUNT))
                   ? adcah_pkg::RANGE_WIDEST : stored;

  adcah_eval u_eval (
    .channel     (s1_channel),
    .sample_code (s1_raw),
    .cur_range   (cur_range),
    .cfg         (cfg),
    .result      (result)
  );

  assign advance   = !res.valid || res.ready;
  assign fire      = s1_valid && advance;
  assign smp.ready = !s1_valid || advance;

  always_comb begin
    sample_count_next = sample_count + 1'b1;
    if (sample_count_next == '0) begin
      sample_count_next = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (smp.ready) begin
      s1_valid <= smp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (smp.ready && smp.valid) begin
      s1_channel <= smp.channel;
      s1_raw     <= smp.sample_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < adcah_pkg::CHANNELS; i++) begin
        chan_range[i] <= adcah_pkg::RANGE_WIDEST;
      end
      sample_count <= '0;
      res.valid    <= 1'b0;
    end else begin
      if (fire) begin
        if (ch_ok) begin
          chan_range[s1_channel[adcah_pkg::CH_IDX_W-1:0]] <= result.next_range;
        end
        sample_count <= sample_count_next;
        res.valid    <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.tenth_mv         <= result.tenth_mv;
      res.range_used       <= result.range_used;
      res.next_range       <= result.next_range;
      res.next_config_word <= result.next_config_word;
      res.settle_count     <= result.settle_count;
      res.generation       <= sample_count_next;
    end
  end

  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.generation != '0)
    else $error("Result generation is zero.");

  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (32'(res.range_used) < 32'(adcah_pkg::RANGE_COUNT)) &&
                  (32'(res.next_range) < 32'(adcah_pkg::RANGE_COUNT)))
    else $error("Result range beyond the last range.");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.next_range == res.range_used) ||
                  (res.next_range == res.range_used + 2'd1) ||
                  (res.range_used == res.next_range + 2'd1))
    else $error("Range moved by more than one step.");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && !s1_valid |=> !res.valid)
    else $error("Result shown with no request behind it.");

endmodule

[hw/rtl/adcah_cfg_regs.sv]
// Configuration register file with the data rate code and hysteresis levels.
module adcah_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [adcah_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adcah_pkg::CFG_DATA_W-1:0]    cfg_data,
  output adcah_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_code    <= adcah_pkg::RATE_CODE_RST;
      cfg.up_level_0   <= adcah_pkg::UP_LEVEL_0_RST;
      cfg.up_level_1   <= adcah_pkg::UP_LEVEL_1_RST;
      cfg.down_level_1 <= adcah_pkg::DOWN_LEVEL_1_RST;
      cfg.down_level_2 <= adcah_pkg::DOWN_LEVEL_2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adcah_pkg::REG_RATE_CODE:    cfg.rate_code    <= cfg_data[adcah_pkg::RATE_W-1:0];
        adcah_pkg::REG_UP_LEVEL_0:   cfg.up_level_0   <= cfg_data;
        adcah_pkg::REG_UP_LEVEL_1:   cfg.up_level_1   <= cfg_data;
        adcah_pkg::REG_DOWN_LEVEL_1: cfg.down_level_1 <= cfg_data;
        adcah_pkg::REG_DOWN_LEVEL_2: cfg.down_level_2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/adcah_eval.sv]
// Scaling, hysteresis range step and config word generation for one request.
module adcah_eval (
  input  logic [adcah_pkg::CH_W-1:0]           channel,
  input  logic signed [adcah_pkg::CODE_W-1:0]  sample_code,
  input  logic [adcah_pkg::RANGE_W-1:0]        cur_range,
  input  adcah_pkg::cfg_t                      cfg,
  output adcah_pkg::result_t                   result
);

  logic                               positive;
  logic [adcah_pkg::PROD_W-1:0]       prod;
  logic [adcah_pkg::VALUE_W-1:0]      value;
  logic                               up_ok;
  logic                               down_ok;
  logic [adcah_pkg::RANGE_W:0]        cur_plus;
  logic [adcah_pkg::RANGE_W-1:0]      next;
  logic [2:0]                         mux_code;

  assign positive = !sample_code[adcah_pkg::CODE_W-1] && (sample_code != '0);
  assign prod = adcah_pkg::PROD_W'(sample_code[adcah_pkg::CODE_W-2:0])
              * adcah_pkg::PROD_W'(adcah_pkg::full_scale_x10(cur_range))
              + adcah_pkg::ROUND_HALF;
  assign value = positive
               ? prod[adcah_pkg::SCALE_SHIFT +: adcah_pkg::VALUE_W]
               : '0;

  always_comb begin
    up_ok   = 1'b0;
    down_ok = 1'b0;
    unique case (cur_range)
      2'd0: up_ok = {1'b0, value} >= cfg.up_level_0;
      2'd1: begin
        up_ok   = {1'b0, value} >= cfg.up_level_1;
        down_ok = {1'b0, value} <= cfg.down_level_1;
      end
      2'd2: down_ok = {1'b0, value} <= cfg.down_level_2;
      default: ;
    endcase
  end

  assign cur_plus = {1'b0, cur_range} + 1'b1;

  always_comb begin
    if ((32'(cur_plus) < 32'(adcah_pkg::RANGE_COUNT)) && up_ok) begin
      next = cur_plus[adcah_pkg::RANGE_W-1:0];
    end else if ((cur_range != '0) && down_ok) begin
      next = cur_range - 1'b1;
    end else begin
      next = cur_range;
    end
  end

  assign mux_code = adcah_pkg::MUX_SINGLE_BASE + 3'(channel);

  assign result.tenth_mv         = value;
  assign result.range_used       = cur_range;
  assign result.next_range       = next;
  assign result.next_config_word = {1'b1, mux_code, adcah_pkg::pga_code(next), 1'b1,
                                    cfg.rate_code, 3'b000, adcah_pkg::COMP_OFF};
  assign result.settle_count     = adcah_pkg::is_narrowest(next)
                                 ? adcah_pkg::SETTLE_LONG : adcah_pkg::SETTLE_SHORT;

endmodule
